// File: rtl/core/tcrc_pkg.sv
// Package: shared types and constants for the three-channel root counter.
package tcrc_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  offset;
		logic [15:0] wdata;
	} in_item_t;

	typedef struct packed {
		logic [15:0] rdata;
		logic [2:0]  irq_raised;
		logic        bad_access;
	} out_item_t;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] SEL_COUNT  = 2'd0;
	localparam logic [1:0] SEL_MODE   = 2'd1;
	localparam logic [1:0] SEL_TARGET = 2'd2;

	localparam logic [1:0] REG_BATCH = 2'd0;
	localparam logic [1:0] REG_DOT   = 2'd1;
	localparam logic [1:0] REG_SYS8  = 2'd2;
	localparam logic [1:0] REG_HBL   = 2'd3;

	localparam int MODE_IRQ_TGT  = 4;
	localparam int MODE_IRQ_FFFF = 5;
	localparam int MODE_TOGGLE   = 7;
	localparam int MODE_REQ      = 10;
	localparam int MODE_HIT_TGT  = 11;
	localparam int MODE_HIT_FFFF = 12;

	localparam logic [15:0] MODE_RESET = 16'h0400;
	localparam logic [15:0] CNT_MAX    = 16'hffff;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;      // capture request, start divisions
		logic       div_step;  // one restoring division step on all sources
		logic       chan_step; // update the channel selected by chan
		logic [1:0] chan;
		logic       bus_op;    // perform bus read or write
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
	} dp_sts_t;

endpackage

// File: rtl/core/tcrc_datapath.sv
// Datapath: registers, serial dividers, channel update and bus access.
module tcrc_datapath #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  tcrc_pkg::in_item_t   req,
	input  tcrc_pkg::dp_cmd_t    dcmd,
	output tcrc_pkg::dp_sts_t    sts,
	output tcrc_pkg::out_item_t  result
);

	logic [15:0] batch_q, dot_q, sys8_q, hbl_q;
	logic [15:0] cnt_q [3];
	logic [15:0] mode_q [3];
	logic [15:0] tgt_q [3];
	logic [15:0] rem_q [3];   // remainder is always below a 16-bit divisor
	logic [16:0] quo_q [3];   // quotient shift register / dividend
	logic [16:0] part_q [3];  // partial remainder
	logic [15:0] div_q [3];
	tcrc_pkg::in_item_t req_q;
	logic [15:0] rdata_q;
	logic [2:0]  irq_q;
	logic        bad_q;

	assign sts.cmd = req_q.cmd;
	assign result.rdata = rdata_q;
	assign result.irq_raised = irq_q;
	assign result.bad_access = bad_q;

	// decode of the captured bus address
	logic [1:0] chan_a, sel_a;
	logic       ok_a;
	assign chan_a = req_q.offset[5:4];
	assign sel_a  = req_q.offset[3:2];
	assign ok_a   = (req_q.offset[1:0] == 2'b00) && (sel_a != 2'd3)
		&& ({30'd0, chan_a} < NUM_CHANNELS);

	// divisors for the three sources, zero reads as one
	logic [15:0] dv [3];
	assign dv[0] = (dot_q == 16'd0) ? 16'd1 : dot_q;
	assign dv[1] = (sys8_q == 16'd0) ? 16'd1 : sys8_q;
	assign dv[2] = (hbl_q == 16'd0) ? 16'd1 : hbl_q;

	// channel update for the selected channel
	// sum needs 18 bits: a 16-bit count plus a 17-bit quotient
	logic [1:0]  c;
	logic [15:0] m, cnt_old, tgt;
	logic [16:0] delta;
	logic [17:0] after;
	logic        hit_t, hit_f, raise;
	logic [15:0] m_new;
	always_comb begin
		c = dcmd.chan;
		m = mode_q[c];
		cnt_old = cnt_q[c];
		tgt = tgt_q[c];
		delta = {1'b0, batch_q};
		if (c == 2'd0 && m[8]) delta = quo_q[0];
		else if (c == 2'd1 && m[8]) delta = quo_q[2];
		else if (c == 2'd2 && m[9]) delta = quo_q[1];
		after = {2'b00, cnt_old} + {1'b0, delta};
		hit_t = (cnt_old < tgt) && (after >= {2'b00, tgt});
		hit_f = (cnt_old < tcrc_pkg::CNT_MAX) && (after >= {2'b00, tcrc_pkg::CNT_MAX});
		m_new = m;
		if (hit_t) m_new[tcrc_pkg::MODE_HIT_TGT] = 1'b1;
		if (hit_f) m_new[tcrc_pkg::MODE_HIT_FFFF] = 1'b1;
		raise = (m_new[tcrc_pkg::MODE_IRQ_FFFF] && hit_f)
			|| (m_new[tcrc_pkg::MODE_IRQ_TGT] && hit_t);
		if (raise) m_new[tcrc_pkg::MODE_REQ] = 1'b0;
		else if (!m_new[tcrc_pkg::MODE_TOGGLE]) m_new[tcrc_pkg::MODE_REQ] = 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= 16'd64;
			dot_q   <= 16'd5;
			sys8_q  <= 16'd8;
			hbl_q   <= 16'd3413;
		end else if (cfg_we) begin
			case (cfg_index)
				tcrc_pkg::REG_BATCH: batch_q <= cfg_wdata;
				tcrc_pkg::REG_DOT:   dot_q   <= cfg_wdata;
				tcrc_pkg::REG_SYS8:  sys8_q  <= cfg_wdata;
				tcrc_pkg::REG_HBL:   hbl_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// state registers and serial dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cnt_q[k]  <= '0;
				mode_q[k] <= tcrc_pkg::MODE_RESET;
				tgt_q[k]  <= '0;
				rem_q[k]  <= '0;
				quo_q[k]  <= '0;
				part_q[k] <= '0;
				div_q[k]  <= 16'd1;
			end
			irq_q   <= '0;
			rdata_q <= '0;
			bad_q   <= 1'b0;
		end else begin
			if (dcmd.load) begin
				irq_q   <= '0;
				rdata_q <= '0;
				bad_q   <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					quo_q[k]  <= {1'b0, rem_q[k]} + {1'b0, batch_q};
					part_q[k] <= '0;
					div_q[k]  <= dv[k];
				end
			end
			// restoring division, one quotient bit per step
			if (dcmd.div_step) begin
				for (int k = 0; k < 3; k++) begin
					logic [17:0] t;
					t = {part_q[k], quo_q[k][16]} - {2'b00, div_q[k]};
					if (!t[17]) begin
						part_q[k] <= t[16:0];
						quo_q[k]  <= {quo_q[k][15:0], 1'b1};
						rem_q[k]  <= t[15:0];
					end else begin
						part_q[k] <= {part_q[k][15:0], quo_q[k][16]};
						quo_q[k]  <= {quo_q[k][15:0], 1'b0};
						rem_q[k]  <= {part_q[k][14:0], quo_q[k][16]};
					end
				end
			end
			if (dcmd.chan_step) begin
				cnt_q[c]  <= after[15:0];
				mode_q[c] <= m_new;
				irq_q[c]  <= raise;
			end
			if (dcmd.bus_op) begin
				if (!ok_a) begin
					bad_q <= 1'b1;
				end else if (req_q.cmd == tcrc_pkg::CMD_READ) begin
					case (sel_a)
						tcrc_pkg::SEL_COUNT: rdata_q <= cnt_q[chan_a];
						tcrc_pkg::SEL_MODE: begin
							rdata_q <= mode_q[chan_a];
							mode_q[chan_a][tcrc_pkg::MODE_HIT_TGT]  <= 1'b0;
							mode_q[chan_a][tcrc_pkg::MODE_HIT_FFFF] <= 1'b0;
						end
						default: rdata_q <= tgt_q[chan_a];
					endcase
				end else begin
					case (sel_a)
						tcrc_pkg::SEL_COUNT: cnt_q[chan_a] <= req_q.wdata;
						tcrc_pkg::SEL_MODE: begin
							mode_q[chan_a] <= req_q.wdata | tcrc_pkg::MODE_RESET;
							cnt_q[chan_a]  <= '0;
						end
						default: tgt_q[chan_a] <= req_q.wdata;
					endcase
				end
			end
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (dcmd.load) req_q <= req;
	end

endmodule

// File: rtl/core/tcrc_ctrl.sv
// Controller: sequences divisions, channel updates, bus access and handshake.
module tcrc_ctrl #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tcrc_pkg::dp_sts_t sts,
	output tcrc_pkg::dp_cmd_t dcmd
);

	typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_DIV, ST_CHAN, ST_BUS, ST_DONE} state_t;
	state_t state_q;
	logic [4:0] step_q;
	logic [1:0] chan_q;

	// a new request waits until the previous result has been taken
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_comb begin
		dcmd = '0;
		dcmd.load = in_valid && in_ready;
		dcmd.div_step = (state_q == ST_DIV);
		dcmd.chan_step = (state_q == ST_CHAN);
		dcmd.chan = chan_q;
		dcmd.bus_op = (state_q == ST_BUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			chan_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					step_q <= '0;
					chan_q <= '0;
					if (sts.cmd == tcrc_pkg::CMD_TICK) state_q <= ST_DIV;
					else if (sts.cmd == tcrc_pkg::CMD_READ || sts.cmd == tcrc_pkg::CMD_WRITE)
						state_q <= ST_BUS;
					else state_q <= ST_DONE;
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd16) state_q <= ST_CHAN;
				end
				ST_CHAN: begin
					chan_q <= chan_q + 2'd1;
					if ({30'd0, chan_q} == NUM_CHANNELS - 1) state_q <= ST_DONE;
				end
				ST_BUS: state_q <= ST_DONE;
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/three_channel_root_counter_core.sv
// Top level of the three-channel root counter.
// One request is handled at a time. A tick request passes, after acceptance,
// through a decode state, 17 steps of three parallel restoring dividers (one
// quotient bit each per cycle, dividend up to 17 bits), a counter update per
// channel in turn, and a done state that loads the result. A bus read or write
// passes through decode, bus and done states, an unused command through decode
// and done. The result stays in an output register until taken; the next
// request is accepted in the cycle after that result has left.
module three_channel_root_counter_core #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcrc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tcrc_pkg::out_item_t out_data
);

	tcrc_pkg::dp_cmd_t dcmd;
	tcrc_pkg::dp_sts_t sts;

	tcrc_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .dcmd(dcmd)
	);

	tcrc_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(in_data), .dcmd(dcmd), .sts(sts),
		.result(out_data)
	);

endmodule

// File: rtl/core/tcrc_checker.sv
// Checker: port-level properties of the root counter, bound to the top level.
module tcrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tcrc_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_bad_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_access |-> out_data.rdata == 16'd0
			&& out_data.irq_raised == 3'd0)
		else $error("bad access carries data");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while result pending");

endmodule

bind three_channel_root_counter_core tcrc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
